// ===== design/uer_pkg.sv =====
// Shared widths, register indexes, reset values and conversion constants of the echo ranger.
package uer_pkg;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_PULSE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_DISTANCE  = 2'd3;

    // Field and counter widths.
    localparam int PERIOD_W  = 20;
    localparam int TIMEOUT_W = 16;
    localparam int PULSE_W   = 8;
    localparam int DIST_W    = 14;
    localparam int ECHO_W    = 16;

    // Register reset values.
    localparam logic [PERIOD_W-1:0]  RST_TRIGGER_PERIOD = 20'd100000;
    localparam logic [TIMEOUT_W-1:0] RST_ECHO_TIMEOUT   = 16'd40000;
    localparam logic [PULSE_W-1:0]   RST_TRIGGER_PULSE  = 8'd10;
    localparam logic [DIST_W-1:0]    RST_NEAR_DISTANCE  = 14'd200;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX     = {PERIOD_W{1'b1}};
    localparam logic [PULSE_W-1:0]  TRIG_LOW_TICKS = 8'd2;

    // Distance is pulse * 343 / 2000, done as a multiply by a rounded-up
    // reciprocal and a shift. With a 28-bit shift the rounding error stays
    // below 1/2000 for every 16-bit pulse, so the floor is exact.
    localparam longint unsigned SOUND_NUM   = 343;
    localparam longint unsigned SOUND_DEN   = 2000;
    localparam int              RECIP_SHIFT = 28;
    localparam int              RECIP_W     = 26;
    localparam longint unsigned RECIP_FULL  =
        ((SOUND_NUM << RECIP_SHIFT) + SOUND_DEN - 1) / SOUND_DEN;
    localparam logic [RECIP_W-1:0] DIST_RECIP = RECIP_W'(RECIP_FULL);
    localparam int              PROD_W      = ECHO_W + RECIP_W;

endpackage

// ===== design/ultrasonic_echo_ranger_core.sv =====
// Top level of the ultrasonic echo ranger: trigger sequencing, echo timing and result stream.
//
// The block is fed one transaction per microsecond tick on the s_axis channel; bit 0 of
// s_axis_tdata is the sampled echo pin level. For every accepted input transaction exactly
// one result transaction leaves on the m_axis channel, carrying the trigger pin level for
// that tick, the valid flag, the last distance in millimeters and echo width, a new-sample
// strobe, the obstacle-near flag and a timeout strobe.
// All work for one tick is combinational: the tick is accepted, the measurement state
// advances, and the result lands in the output register (skid register on a stall) at the
// same clock edge, one tick per cycle while the output stage is not full. The longest path
// is the 16 by 26 bit multiply from echo width to millimeters, followed by the near compare.
// A two-entry output stage (output register plus skid register) decouples the channels:
// s_axis_tready depends only on the skid register, so a stalled receiver costs nothing
// until both entries are full, and then input stops until the receiver takes a result.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle, clears all counters and
// stored results, empties the output stage and loads the default register values.
// Configuration is written through i_cfg_wr_en, i_cfg_index and i_cfg_wr_data and takes
// effect on the next tick; it should only be written while no result is outstanding.
module ultrasonic_echo_ranger_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_wr_en,
    input  logic [uer_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0] i_cfg_wr_data,
    // Input tick stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata fields from bit 0: echo_level[0], zero padding [7:1].
    input  logic [uer_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // Result stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata fields from bit 0: trig_level[0], sample_valid[1], range_mm[15:2],
    // echo_pulse_us[31:16], new_sample[32], obstacle_near[33], timed_out[34],
    // zero padding [39:35].
    output logic [uer_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // Sequencer phases.
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_TRIG_LOW  = 3'd1;
    localparam logic [2:0] PH_TRIG_HIGH = 3'd2;
    localparam logic [2:0] PH_WAIT      = 3'd3;
    localparam logic [2:0] PH_CAPTURE   = 3'd4;

    // Configuration registers.
    logic [uer_pkg::PERIOD_W-1:0]  r_trigger_period;
    logic [uer_pkg::TIMEOUT_W-1:0] r_echo_timeout;
    logic [uer_pkg::PULSE_W-1:0]   r_trigger_pulse;
    logic [uer_pkg::DIST_W-1:0]    r_near_distance;

    // Measurement state.
    logic [2:0]                    r_phase,          n_phase;
    logic [uer_pkg::PERIOD_W-1:0]  r_period_count,   n_period_count;
    logic [uer_pkg::PULSE_W-1:0]   r_trig_count,     n_trig_count;
    logic [uer_pkg::TIMEOUT_W-1:0] r_wait_count,     n_wait_count;
    logic                          r_echo_prev;
    logic [uer_pkg::DIST_W-1:0]    r_distance_store, n_distance_store;
    logic [uer_pkg::ECHO_W-1:0]    r_pulse_store,    n_pulse_store;
    logic                          r_valid_flag,     n_valid_flag;

    // Output stage.
    logic                          r_out_valid;
    logic [uer_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                          r_skid_valid;
    logic [uer_pkg::OUT_DATA_W-1:0] r_skid_data;

    logic                          w_accept;
    logic                          w_echo;
    logic                          w_rise;
    logic [uer_pkg::PULSE_W-1:0]   w_pulse_len;
    logic [uer_pkg::PULSE_W-1:0]   w_trig_inc;
    logic [uer_pkg::PROD_W-1:0]    w_dist_prod;
    logic                          w_trig;
    logic                          w_new_sample;
    logic                          w_timed_out;
    logic                          w_near;
    logic [uer_pkg::OUT_DATA_W-1:0] w_result;

    assign s_axis_tready = !r_skid_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_echo        = s_axis_tdata[0];
    assign w_rise        = w_echo && !r_echo_prev;

    // A zero trigger width behaves as a one-tick pulse.
    assign w_pulse_len = (r_trigger_pulse == '0) ? uer_pkg::PULSE_W'(1) : r_trigger_pulse;

    // The pulse that gets stored is always the current wait count, so the
    // multiplier works straight from a register.
    assign w_dist_prod = uer_pkg::PROD_W'(r_wait_count) * uer_pkg::PROD_W'(uer_pkg::DIST_RECIP);

    always_comb begin
        n_phase          = r_phase;
        n_trig_count     = r_trig_count;
        n_wait_count     = r_wait_count;
        n_distance_store = r_distance_store;
        n_pulse_store    = r_pulse_store;
        n_valid_flag     = r_valid_flag;
        w_trig           = 1'b0;
        w_new_sample     = 1'b0;
        w_timed_out      = 1'b0;
        w_trig_inc       = '0;

        // Ticks since the last start, saturating.
        if (r_period_count == uer_pkg::PERIOD_MAX) begin
            n_period_count = r_period_count;
        end else begin
            n_period_count = r_period_count + 1'b1;
        end

        // Start a new measurement; this tick is already the first trigger-low tick.
        if ((r_phase == PH_IDLE) && (n_period_count >= r_trigger_period)) begin
            n_period_count = '0;
            n_trig_count   = '0;
            n_phase        = PH_TRIG_LOW;
        end

        case (n_phase)
            PH_TRIG_LOW: begin
                w_trig_inc = n_trig_count + 1'b1;
                if (w_trig_inc >= uer_pkg::TRIG_LOW_TICKS) begin
                    n_trig_count = '0;
                    n_phase      = PH_TRIG_HIGH;
                end else begin
                    n_trig_count = w_trig_inc;
                end
            end
            PH_TRIG_HIGH: begin
                w_trig     = 1'b1;
                w_trig_inc = n_trig_count + 1'b1;
                if (w_trig_inc >= w_pulse_len) begin
                    n_trig_count = '0;
                    n_wait_count = '0;
                    n_phase      = PH_WAIT;
                end else begin
                    n_trig_count = w_trig_inc;
                end
            end
            PH_WAIT: begin
                if (!w_rise) begin
                    // Still waiting for the echo to rise.
                    if (r_wait_count >= r_echo_timeout) begin
                        n_valid_flag = 1'b0;
                        w_timed_out  = 1'b1;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_wait_count = r_wait_count + 1'b1;
                    end
                end else if (r_echo_timeout == '0) begin
                    // Rising tick with a zero timeout: the pulse is already too long.
                    n_valid_flag = 1'b0;
                    w_timed_out  = 1'b1;
                    n_phase      = PH_IDLE;
                end else begin
                    // The rising tick is the first counted tick of the pulse.
                    n_wait_count = uer_pkg::TIMEOUT_W'(1);
                    n_phase      = PH_CAPTURE;
                end
            end
            PH_CAPTURE: begin
                if (w_echo) begin
                    if (r_wait_count >= r_echo_timeout) begin
                        n_valid_flag = 1'b0;
                        w_timed_out  = 1'b1;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_wait_count = r_wait_count + 1'b1;
                    end
                end else begin
                    // Falling edge: store the width and its distance.
                    n_pulse_store    = r_wait_count;
                    n_distance_store = w_dist_prod[uer_pkg::RECIP_SHIFT +: uer_pkg::DIST_W];
                    n_valid_flag     = 1'b1;
                    w_new_sample     = 1'b1;
                    n_phase          = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    assign w_near = n_valid_flag && (n_distance_store < r_near_distance);

    assign w_result = {5'b0, w_timed_out, w_near, w_new_sample,
                       n_pulse_store, n_distance_store, n_valid_flag, w_trig};

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_period <= uer_pkg::RST_TRIGGER_PERIOD;
            r_echo_timeout   <= uer_pkg::RST_ECHO_TIMEOUT;
            r_trigger_pulse  <= uer_pkg::RST_TRIGGER_PULSE;
            r_near_distance  <= uer_pkg::RST_NEAR_DISTANCE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                uer_pkg::CFG_TRIGGER_PERIOD: begin
                    r_trigger_period <= i_cfg_wr_data[uer_pkg::PERIOD_W-1:0];
                end
                uer_pkg::CFG_ECHO_TIMEOUT: begin
                    r_echo_timeout <= i_cfg_wr_data[uer_pkg::TIMEOUT_W-1:0];
                end
                uer_pkg::CFG_TRIGGER_PULSE: begin
                    r_trigger_pulse <= i_cfg_wr_data[uer_pkg::PULSE_W-1:0];
                end
                uer_pkg::CFG_NEAR_DISTANCE: begin
                    r_near_distance <= i_cfg_wr_data[uer_pkg::DIST_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Measurement state advances once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_period_count   <= '0;
            r_trig_count     <= '0;
            r_wait_count     <= '0;
            r_echo_prev      <= 1'b0;
            r_distance_store <= '0;
            r_pulse_store    <= '0;
            r_valid_flag     <= 1'b0;
        end else if (w_accept) begin
            r_phase          <= n_phase;
            r_period_count   <= n_period_count;
            r_trig_count     <= n_trig_count;
            r_wait_count     <= n_wait_count;
            r_echo_prev      <= w_echo;
            r_distance_store <= n_distance_store;
            r_pulse_store    <= n_pulse_store;
            r_valid_flag     <= n_valid_flag;
        end
    end

    // Output register with skid entry. Input is refused only while the skid
    // entry holds a result, so no accepted transaction can be dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (w_accept) begin
                r_out_data <= w_result;
            end
        end else if (w_accept) begin
            r_skid_data <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
